// ----- sv/irpw_pkg.sv -----
// irpw_pkg: shared constants for the IR pulse-width character decoder.
// No dependencies; used by ir_pulse_width_char_decoder.
`default_nettype none

package irpw_pkg;

    // Threshold register width and reset values
    localparam int unsigned REG_W = 14;
    localparam int unsigned GAP_BITS_DEF = 14;

    localparam logic [REG_W-1:0] ZERO_MAX_RST = 14'd800;
    localparam logic [REG_W-1:0] ONE_MAX_RST  = 14'd1600;
    localparam logic [REG_W-1:0] CHAR_GAP_RST = 14'd2800;
    localparam logic [REG_W-1:0] LINE_GAP_RST = 14'd10000;

    // Register indexes on the config port
    typedef enum logic [1:0] {
        CFG_ZERO_MAX = 2'd0,
        CFG_ONE_MAX  = 2'd1,
        CFG_CHAR_GAP = 2'd2,
        CFG_LINE_GAP = 2'd3
    } t_cfg_idx;

    // Frame bit index codes
    localparam logic [3:0] IDX_IDLE = 4'd15;
    localparam logic [3:0] IDX_FULL = 4'd8;
    localparam logic [3:0] IDX_ZERO = 4'd0;

endpackage

`default_nettype wire

// ----- sv/ir_pulse_width_char_decoder.sv -----
// Each accepted input beat loads its result beat into the output register.
// Throughput: one input beat per cycle; the output register frees in the same cycle it is
// taken, so the input stalls only while a result sits untaken downstream.
// Reset (i_rst_n low, synchronous): thresholds back to 800/1600/2800/10000, no frame open,
// gap counter and line flag cleared, output register empty. No clearing pass.
// Depends on irpw_pkg.
`default_nettype none

module ir_pulse_width_char_decoder #(
    parameter int unsigned GAP_BITS = irpw_pkg::GAP_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // config write port
    input  wire                          i_cfg_we,
    input  wire  [1:0]                   i_cfg_idx,
    input  wire  [irpw_pkg::REG_W-1:0]   i_cfg_data,
    // input channel: one pin sample per microsecond tick
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire                          i_ir_level,
    // result channel
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic                         o_char_valid,
    output logic [7:0]                   o_char_value,
    output logic                         o_newline_valid
);

    // Compare width covers both the gap counter and the 14-bit thresholds
    localparam int unsigned CMP_W =
        (GAP_BITS > irpw_pkg::REG_W) ? GAP_BITS : irpw_pkg::REG_W;

    // ---------------- threshold registers ----------------
    logic [irpw_pkg::REG_W-1:0] r_zero_max, r_one_max, r_char_gap, r_line_gap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_max <= irpw_pkg::ZERO_MAX_RST;
            r_one_max  <= irpw_pkg::ONE_MAX_RST;
            r_char_gap <= irpw_pkg::CHAR_GAP_RST;
            r_line_gap <= irpw_pkg::LINE_GAP_RST;
        end else if (i_cfg_we) begin
            unique case (irpw_pkg::t_cfg_idx'(i_cfg_idx))
                irpw_pkg::CFG_ZERO_MAX: r_zero_max <= i_cfg_data;
                irpw_pkg::CFG_ONE_MAX:  r_one_max  <= i_cfg_data;
                irpw_pkg::CFG_CHAR_GAP: r_char_gap <= i_cfg_data;
                irpw_pkg::CFG_LINE_GAP: r_line_gap <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- decoder state ----------------
    logic                r_prev_level, n_prev_level;
    logic [GAP_BITS-1:0] r_gap_count,  n_gap_count;
    logic [3:0]          r_bit_idx,    n_bit_idx;
    logic [7:0]          r_shift_char, n_shift_char;
    logic                r_line_sent,  n_line_sent;

    // output register
    logic       r_out_valid;
    logic       r_char_valid, n_char_valid;
    logic [7:0] r_char_value, n_char_value;
    logic       r_nl_valid,   n_nl_valid;

    // Output register accepts a new beat when empty or being drained this cycle
    logic in_fire;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    // Elapsed time, saturating at all ones
    logic [GAP_BITS-1:0] elapsed;
    logic [CMP_W-1:0]    elapsed_x;
    assign elapsed   = (&r_gap_count) ? r_gap_count : r_gap_count + GAP_BITS'(1);
    assign elapsed_x = CMP_W'(elapsed);

    logic is_short, is_medium;
    assign is_short  = elapsed_x < CMP_W'(r_zero_max);
    assign is_medium = elapsed_x < CMP_W'(r_one_max);

    logic [2:0] set_pos;   // bit 7 minus the index: first bit lands in bit 7
    assign set_pos = 3'd7 - r_bit_idx[2:0];

    always_comb begin
        n_prev_level = r_prev_level;
        n_gap_count  = r_gap_count;
        n_bit_idx    = r_bit_idx;
        n_shift_char = r_shift_char;
        n_line_sent  = r_line_sent;
        n_char_valid = 1'b0;
        n_char_value = 8'd0;
        n_nl_valid   = 1'b0;

        if (i_ir_level == r_prev_level) begin
            // Quiet tick: advance the gap and check for end of char / line
            n_gap_count = elapsed;
            if (elapsed_x > CMP_W'(r_char_gap) && r_bit_idx == irpw_pkg::IDX_FULL) begin
                n_char_valid = 1'b1;
                n_char_value = r_shift_char;
                n_bit_idx    = irpw_pkg::IDX_IDLE;
                n_shift_char = 8'd0;
            end
            if (elapsed_x > CMP_W'(r_line_gap) && !r_line_sent) begin
                n_nl_valid  = 1'b1;
                n_line_sent = 1'b1;
            end
        end else begin
            // Edge tick; only a rising edge ends a low pulse worth classifying
            if (i_ir_level) begin
                priority if (r_bit_idx > irpw_pkg::IDX_FULL) begin
                    // no frame open: any pulse opens one
                    n_bit_idx    = irpw_pkg::IDX_ZERO;
                    n_shift_char = 8'd0;
                end else if (is_short) begin
                    if (r_bit_idx < irpw_pkg::IDX_FULL)
                        n_bit_idx = r_bit_idx + 4'd1;
                end else if (is_medium) begin
                    if (r_bit_idx < irpw_pkg::IDX_FULL) begin
                        n_shift_char          = r_shift_char;
                        n_shift_char[set_pos] = 1'b1;
                        n_bit_idx             = r_bit_idx + 4'd1;
                    end
                end else begin
                    // long pulse restarts the frame
                    n_bit_idx    = irpw_pkg::IDX_ZERO;
                    n_shift_char = 8'd0;
                end
            end
            n_gap_count  = '0;
            n_line_sent  = 1'b0;
            n_prev_level = i_ir_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level <= 1'b0;
            r_gap_count  <= '0;
            r_bit_idx    <= irpw_pkg::IDX_IDLE;
            r_shift_char <= 8'd0;
            r_line_sent  <= 1'b0;
        end else if (in_fire) begin
            r_prev_level <= n_prev_level;
            r_gap_count  <= n_gap_count;
            r_bit_idx    <= n_bit_idx;
            r_shift_char <= n_shift_char;
            r_line_sent  <= n_line_sent;
        end
    end

    // Result register: valid flag under reset, payload loaded on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_char_valid <= n_char_valid;
            r_char_value <= n_char_value;
            r_nl_valid   <= n_nl_valid;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_char_valid    = r_char_valid;
    assign o_char_value    = r_char_value;
    assign o_newline_valid = r_nl_valid;

    // ---------------- assertions ----------------
    // Bit index is either a count 0..8 or the idle code
    a_idx_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bit_idx <= irpw_pkg::IDX_FULL) || (r_bit_idx == irpw_pkg::IDX_IDLE))
        else $error("bit index left legal range");

    // Delivering a character closes the frame
    a_char_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && n_char_valid) |=> (r_bit_idx == irpw_pkg::IDX_IDLE && o_char_valid))
        else $error("character delivered without closing frame");

    // A newline marks the silence as reported
    a_nl_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && n_nl_valid) |=> (r_line_sent && o_newline_valid))
        else $error("newline not recorded");

    // An edge clears the gap counter
    a_edge_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_ir_level != r_prev_level)) |=> (r_gap_count == '0 && !r_line_sent))
        else $error("gap not cleared on edge");

endmodule

`default_nettype wire

// ----- dv/ir_pulse_width_char_decoder_chk.sv -----
`timescale 1ns / 100ps
// ir_pulse_width_char_decoder_chk: watches both channels of the IR character decoder,
// predicts one result beat per accepted pin sample and compares them in order.
// Depends on irpw_pkg for register widths, index codes and frame index codes.
module ir_pulse_width_char_decoder_chk #(
    parameter int unsigned GAP_BITS = irpw_pkg::GAP_BITS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_we,
    input  wire  [1:0]                 i_cfg_idx,
    input  wire  [irpw_pkg::REG_W-1:0] i_cfg_data,
    input  wire                        i_in_valid,
    input  wire                        i_in_ready,
    input  wire                        i_ir_level,
    input  wire                        i_out_valid,
    input  wire                        i_out_ready,
    input  wire                        i_char_valid,
    input  wire  [7:0]                 i_char_value,
    input  wire                        i_newline_valid,
    output int                         o_fail_count,
    output int                         o_pending
);

    typedef struct packed {
        logic       char_valid;
        logic [7:0] char_value;
        logic       newline_valid;
    } t_tick_result;

    // thresholds
    logic [irpw_pkg::REG_W-1:0] zero_max, one_max, char_gap, line_gap;
    // decoder state
    logic                level_q;
    logic [GAP_BITS-1:0] gap_cnt;
    logic [3:0]          frame_idx;
    logic [7:0]          char_acc;
    logic                newline_done;

    t_tick_result tick_results_q[$];
    int           mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch: %s got %0d want %0d", $time, what, got, want);
        mismatches++;
    endtask

    function automatic void open_frame();
        frame_idx = irpw_pkg::IDX_ZERO;
        char_acc  = '0;
    endfunction

    // One microsecond tick of the decoder.
    function automatic t_tick_result decode_tick(input logic lvl);
        logic [GAP_BITS-1:0] elapsed;
        t_tick_result        res;
        res     = '0;
        elapsed = (gap_cnt == {GAP_BITS{1'b1}}) ? gap_cnt : gap_cnt + 1'b1;
        if (lvl == level_q) begin
            gap_cnt = elapsed;
            if (elapsed > char_gap && frame_idx == irpw_pkg::IDX_FULL) begin
                res.char_valid = 1'b1;
                res.char_value = char_acc;
                frame_idx      = irpw_pkg::IDX_IDLE;
                char_acc       = '0;
            end
            if (elapsed > line_gap && !newline_done) begin
                res.newline_valid = 1'b1;
                newline_done      = 1'b1;
            end
        end else begin
            if (lvl) begin
                // rising edge ends a low pulse; open-frame test first, then the zero test
                if (frame_idx > irpw_pkg::IDX_FULL) begin
                    open_frame();
                end else if (elapsed < zero_max) begin
                    if (frame_idx < irpw_pkg::IDX_FULL) frame_idx = frame_idx + 1'b1;
                end else if (elapsed < one_max) begin
                    if (frame_idx < irpw_pkg::IDX_FULL) begin
                        char_acc[3'd7 - frame_idx[2:0]] = 1'b1;
                        frame_idx = frame_idx + 1'b1;
                    end
                end else begin
                    open_frame();
                end
            end
            gap_cnt      = '0;
            newline_done = 1'b0;
            level_q      = lvl;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_tick_result got, want;
        if (!i_rst_n) begin
            zero_max     = irpw_pkg::ZERO_MAX_RST;
            one_max      = irpw_pkg::ONE_MAX_RST;
            char_gap     = irpw_pkg::CHAR_GAP_RST;
            line_gap     = irpw_pkg::LINE_GAP_RST;
            level_q      = 1'b0;
            gap_cnt      = '0;
            frame_idx    = irpw_pkg::IDX_IDLE;
            char_acc     = '0;
            newline_done = 1'b0;
            tick_results_q.delete();
        end else begin
            // result side first: a beat leaving now was predicted at an earlier edge
            if (i_out_valid && i_out_ready) begin
                got = '{i_char_valid, i_char_value, i_newline_valid};
                if (tick_results_q.size() == 0) begin
                    report_mismatch("result beat with none predicted, char_value",
                                    int'(got.char_value), 0);
                end else begin
                    want = tick_results_q.pop_front();
                    if (got.char_valid !== want.char_valid)
                        report_mismatch("char_valid", int'(got.char_valid),
                                        int'(want.char_valid));
                    if (got.char_value !== want.char_value)
                        report_mismatch("char_value", int'(got.char_value),
                                        int'(want.char_value));
                    if (got.newline_valid !== want.newline_valid)
                        report_mismatch("newline_valid", int'(got.newline_valid),
                                        int'(want.newline_valid));
                end
            end
            if (i_in_valid && i_in_ready)
                tick_results_q.push_back(decode_tick(i_ir_level));
            if (i_cfg_we) begin
                case (irpw_pkg::t_cfg_idx'(i_cfg_idx))
                    irpw_pkg::CFG_ZERO_MAX: zero_max = i_cfg_data;
                    irpw_pkg::CFG_ONE_MAX:  one_max  = i_cfg_data;
                    irpw_pkg::CFG_CHAR_GAP: char_gap = i_cfg_data;
                    irpw_pkg::CFG_LINE_GAP: line_gap = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending <= tick_results_q.size();
    end

endmodule

// ----- dv/ir_pulse_width_char_decoder_tb.sv -----
`timescale 1ns / 100ps
// ir_pulse_width_char_decoder_tb: drives pin samples and threshold writes into the decoder,
// idles both channels, and gives the verdict. Depends on irpw_pkg, the decoder and its checker.
module ir_pulse_width_char_decoder_tb;

    localparam int IDLE_LIMIT = 2000;   // cycles without any beat before giving up

    typedef enum {P_ZERO, P_ONE, P_START} t_pulse_kind;
    // receiver stall patterns
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_THIRDS, RX_BURSTY} t_rx_mode;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cfg_we    = 1'b0;
    logic [1:0]                 cfg_idx   = irpw_pkg::CFG_ZERO_MAX;
    logic [irpw_pkg::REG_W-1:0] cfg_data  = '0;
    logic                       in_valid  = 1'b0;
    logic                       ir_level  = 1'b0;
    logic                       out_ready = 1'b0;
    wire                        in_ready;
    wire                        out_valid;
    wire                        char_valid;
    wire  [7:0]                 char_value;
    wire                        newline_valid;
    int                         fail_count;
    int                         pending;

    // sender / receiver shaping
    int       burst_left = 0;
    bit       calm       = 1'b0;   // no idling on either side while set
    int       beats_sent = 0;
    t_rx_mode rx_mode    = RX_OPEN;
    int       rx_left    = 0;
    int       cyc        = 0;
    int       idle_cycles = 0;

    // thresholds as last written, used to shape pulses
    int cur_zero = int'(irpw_pkg::ZERO_MAX_RST);
    int cur_one  = int'(irpw_pkg::ONE_MAX_RST);
    int cur_char = int'(irpw_pkg::CHAR_GAP_RST);
    int cur_line = int'(irpw_pkg::LINE_GAP_RST);

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ir_pulse_width_char_decoder uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_ir_level      (ir_level),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_char_valid    (char_valid),
        .o_char_value    (char_value),
        .o_newline_valid (newline_valid)
    );

    ir_pulse_width_char_decoder_chk chk (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_ir_level      (ir_level),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_char_valid    (char_valid),
        .i_char_value    (char_value),
        .i_newline_valid (newline_valid),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Receiver: a new random stall pattern each time its countdown runs out, always ready while calm.
    always @(posedge clk) begin
        cyc <= cyc + 1;
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(8, 64);
        end else begin
            rx_left <= rx_left - 1;
        end
        if (calm) begin
            out_ready <= 1'b1;
        end else begin
            case (rx_mode)
                RX_OPEN:   out_ready <= 1'b1;
                RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                RX_THIRDS: out_ready <= (cyc % 3 != 0);
                RX_BURSTY: out_ready <= (cyc % 8 >= 5);
                default:   out_ready <= 1'b1;
            endcase
        end
    end

    // Watchdog: any beat on either channel resets the count.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // One pin sample beat. Bursts of 1..24 beats, each preceded by an idle gap unless calm.
    task automatic send_level(input logic lvl);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = calm ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        ir_level <= lvl;
        do @(posedge clk); while (!in_ready);
        beats_sent++;
    endtask

    // Low for low_n ticks, then high for high_n ticks. Coming from high, the rising
    // edge sees a pulse of low_n ticks.
    task automatic send_pulse(input int low_n, input int high_n);
        repeat (low_n) send_level(1'b0);
        repeat (high_n) send_level(1'b1);
    endtask

    // Stop sending and wait until every predicted result beat has been taken.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Thresholds change only with the decoder drained.
    task automatic write_config(input int z, input int o, input int c, input int l);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_idx  <= irpw_pkg::CFG_ZERO_MAX;
        cfg_data <= irpw_pkg::REG_W'(z);
        @(posedge clk);
        cfg_idx  <= irpw_pkg::CFG_ONE_MAX;
        cfg_data <= irpw_pkg::REG_W'(o);
        @(posedge clk);
        cfg_idx  <= irpw_pkg::CFG_CHAR_GAP;
        cfg_data <= irpw_pkg::REG_W'(c);
        @(posedge clk);
        cfg_idx  <= irpw_pkg::CFG_LINE_GAP;
        cfg_data <= irpw_pkg::REG_W'(l);
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_zero = z;
        cur_one  = o;
        cur_char = c;
        cur_line = l;
    endtask

    // Low time for a pulse of the given kind under the current thresholds. Where a kind
    // cannot occur or would need a very long low, fall back to a short random pulse.
    function automatic int low_ticks(input t_pulse_kind kind);
        int lo;
        case (kind)
            P_ZERO: begin
                if (cur_zero >= 2)
                    return $urandom_range(1, (cur_zero - 1 < 40) ? cur_zero - 1 : 40);
            end
            P_ONE: begin
                lo = (cur_zero > 1) ? cur_zero : 1;
                if (cur_one > lo && lo <= 40)
                    return $urandom_range(lo, (cur_one - 1 < lo + 40) ? cur_one - 1 : lo + 40);
            end
            default: begin
                lo = (cur_one > 1) ? cur_one : 1;
                if (lo <= 40)
                    return $urandom_range(lo, lo + 3);
            end
        endcase
        return $urandom_range(1, 8);
    endfunction

    // Mostly well-formed frames with random bits and random quiet times, plus broken
    // frames, pin noise and an occasional full drain.
    task automatic random_traffic(input int n);
        int stop_at, nbits, pick, quiet_max, gap_top;
        stop_at   = beats_sent + n;
        gap_top   = (cur_char > cur_line) ? cur_char : cur_line;
        quiet_max = (gap_top < 37) ? gap_top + 3 : 40;
        while (beats_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                send_pulse(low_ticks(P_START), $urandom_range(1, 2));
                nbits = ($urandom_range(0, 2) != 0) ? 8 : $urandom_range(0, 10);
                repeat (nbits)
                    send_pulse(low_ticks($urandom_range(0, 1) ? P_ONE : P_ZERO),
                               $urandom_range(1, 2));
                repeat ($urandom_range(0, quiet_max)) send_level(1'b1);
                // sometimes the silence is held low instead
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, quiet_max)) send_level(1'b0);
            end else if (pick < 96) begin
                repeat ($urandom_range(1, 12)) send_level(1'($urandom_range(0, 1)));
            end else begin
                drain_results();
            end
        end
    endtask

    initial begin
        int reset_bits[8] = '{1, 2, 3, 1, 4, 2, 1, 3};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset thresholds: the first pulse opens the frame, eight short lows fill it
        // with zero bits, and a short silence stays well under both gaps.
        send_pulse(1, 1);
        foreach (reset_bits[i]) send_pulse(reset_bits[i], 1);
        repeat (20) send_level(1'b1);

        // Tight thresholds: start, 0xA5, one bit past eight, then a silence that
        // fires the character and the newline on the same tick.
        write_config(2, 3, 2, 2);
        send_level(1'b1);
        send_pulse(3, 1);
        send_pulse(2, 1);
        send_pulse(1, 1);
        send_pulse(2, 1);
        send_pulse(1, 1);
        send_pulse(1, 1);
        send_pulse(2, 1);
        send_pulse(1, 1);
        send_pulse(2, 1);
        send_pulse(2, 1);
        repeat (3) send_level(1'b1);

        // Random phases over several threshold settings.
        write_config(3, 6, 8, 14);
        random_traffic(240);
        calm = 1'b1;
        write_config(2, 5, 3, 3);            // character and newline coincide
        random_traffic(200);
        calm = 1'b0;
        write_config(6, 3, 8, 12);           // zero limit above one limit: no 1 bits
        random_traffic(200);
        write_config(0, 4, 5, 9);            // no 0 bits
        random_traffic(200);
        write_config(0, 0, 0, 0);            // every pulse a start, gaps fire at once
        random_traffic(160);
        write_config(4, 8, 16383, 10);       // character gap never reached
        random_traffic(200);
        write_config(16383, 16383, 16383, 16383);
        random_traffic(100);
        write_config(1, 7, 12, 6);           // newline ahead of the character
        random_traffic(200);
        write_config(3, 9, 10, 16);
        random_traffic(120);

        drain_results();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- ir_pulse_width_char_decoder.f -----
sv/irpw_pkg.sv
sv/ir_pulse_width_char_decoder.sv
dv/ir_pulse_width_char_decoder_chk.sv
dv/ir_pulse_width_char_decoder_tb.sv
